>>> src/ebml_element_header_encoder_core_defines.svh
// Assertion macros for the EBML element header encoder.
// Used by the top level; no other dependencies.
`ifndef EBML_ELEMENT_HEADER_ENCODER_CORE_DEFINES_SVH
`define EBML_ELEMENT_HEADER_ENCODER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Plain property check, clocked, disabled in reset
`define EHE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check on the cycle after a trigger
`define EHE_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);
`else
`define EHE_ASSERT(lbl, clk, rst_n, prop, msg)
`define EHE_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg)
`endif

`endif

>>> src/ehe_pkg.sv
// Shared types and constants for the EBML element header encoder.
// No dependencies.
package ehe_pkg;

	localparam int QUEUE_DEPTH = 2;

	// request types
	localparam logic [1:0] REQ_UINT   = 2'd0;
	localparam logic [1:0] REQ_SIZED  = 2'd1;
	localparam logic [1:0] REQ_MASTER = 2'd2;
	localparam logic [1:0] REQ_MSIZE  = 2'd3;

	localparam logic [7:0] VINT_LEN1_MARK = 8'h80;
	localparam logic [7:0] VINT_LEN8_MARK = 8'h01;

	// One classified request: ID bytes, optional single header byte,
	// then body bytes; byte fields are left aligned (next byte on top).
	typedef struct packed {
		logic [31:0] id_al;
		logic [2:0]  nid;
		logic        hdr_en;
		logic [7:0]  hdr;
		logic [63:0] body_al;
		logic [3:0]  nbody;
		logic        err;
	} desc_t;

endpackage

>>> src/ebml_element_header_encoder_core.sv
// EBML element header encoder, top level: front end, queue, serializer.
// Depends on ehe_pkg, ehe_fifo, ehe_front, ehe_back and the defines header.
//
// Each request yields 1 to 13 bytes, most significant first, one byte per
// cycle on the output while out_ready is high; the serializer starts the next
// request in the cycle after the previous last byte, so bytes of consecutive
// queued requests stream without gaps.
// The input takes one request per cycle while the input register and the
// descriptor queue (QDEPTH entries) have room; a request passes the input
// register, the queue and the serializer's descriptor register before its
// first byte appears. error is set only on a single zero byte that is also
// the last.
`include "ebml_element_header_encoder_core_defines.svh"

module ebml_element_header_encoder_core #(
	parameter int QDEPTH = ehe_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [31:0] elem_id,
	input  logic [63:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last,
	output logic        error
);
	import ehe_pkg::*;

	logic  q_push, q_full, q_pop, q_nempty;
	desc_t q_wdata, q_rdata;

	// classify requests
	ehe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.elem_id  (elem_id),
		.value    (value),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	// decouple front and back
	ehe_fifo #(
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.nempty (q_nempty),
		.rdata  (q_rdata)
	);

	// serialize bytes
	ehe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_nempty  (q_nempty),
		.q_data    (q_rdata),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last      (last),
		.error     (error)
	);

	// an error result is a single zero byte
	`EHE_ASSERT(a_err_single, clk, arst_n, !(out_valid && error) || (last && out_byte == 8'h00), "error byte must be last and zero")
	// never write into a full queue
	`EHE_ASSERT(a_no_overflow, clk, arst_n, !(q_push && q_full), "queue overflow")
	// output goes idle after a last byte when nothing is queued
	`EHE_ASSERT_NEXT(a_idle_after_last, clk, arst_n, out_valid && out_ready && last && !q_nempty, !out_valid, "output busy without a queued request")

endmodule

>>> src/ehe_fifo.sv
// Small descriptor queue between the classifier and the serializer.
// Depends on ehe_pkg.
module ehe_fifo #(
	parameter int DEPTH = ehe_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ehe_pkg::desc_t wdata,
	output logic           full,
	input  logic           pop,
	output logic           nempty,
	output ehe_pkg::desc_t rdata
);
	import ehe_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	desc_t         mem_q [DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] count_q;

	assign full   = (count_q == CW'(DEPTH));
	assign nempty = (count_q != '0);
	assign rdata  = mem_q[rptr_q];

	// store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> src/ehe_front.sv
// Front end: registers requests and classifies them into descriptors.
// Depends on ehe_pkg.
module ehe_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [1:0]     req_type,
	input  logic [31:0]    elem_id,
	input  logic [63:0]    value,
	input  logic           q_full,
	output logic           q_push,
	output ehe_pkg::desc_t q_data
);
	import ehe_pkg::*;

	logic        valid_s1;
	logic [1:0]  type_s1;
	logic [31:0] id_s1;
	logic [63:0] val_s1;

	logic        in_fire;
	logic [2:0]  nid;
	logic [3:0]  nb;
	logic [3:0]  sz;
	logic [7:0]  ge;
	logic [63:0] marked;
	logic        err1, err3;

	assign q_push   = valid_s1 && !q_full;
	assign in_ready = !valid_s1 || q_push;
	assign in_fire  = in_valid && in_ready;

	// hold the request until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			type_s1 <= req_type;
			id_s1   <= elem_id;
			val_s1  <= value;
		end
	end

	// ID length, value length and minimal vint length
	always_comb begin
		if (id_s1[31:24] != '0) begin
			nid = 3'd4;
		end else if (id_s1[23:16] != '0) begin
			nid = 3'd3;
		end else if (id_s1[15:8] != '0) begin
			nid = 3'd2;
		end else begin
			nid = 3'd1;
		end

		nb = 4'd1;
		for (int k = 1; k < 8; k++) begin
			if (val_s1[8*k +: 8] != '0) begin
				nb = 4'(k + 1);
			end
		end

		// ge[k]: value reaches the all-ones code of a k-byte vint
		ge = '0;
		for (int k = 1; k < 8; k++) begin
			ge[k] = (val_s1 >= ((64'd1 << (7 * k)) - 64'd1));
		end
		sz = 4'd1 + 4'($countones(ge));

		marked = val_s1 | (64'd1 << (6'(sz) * 6'd7));
		err1   = (val_s1[63:56] != '0) || (&val_s1[55:0]);
		err3   = (val_s1[63:56] != '0);
	end

	// build the descriptor
	always_comb begin
		q_data         = '0;
		q_data.id_al   = id_s1 << {(3'd4 - nid), 3'b000};
		q_data.nid     = nid;
		case (type_s1)
			REQ_UINT: begin
				q_data.hdr_en  = 1'b1;
				q_data.hdr     = VINT_LEN1_MARK | 8'(nb);
				q_data.body_al = val_s1 << {(4'd8 - nb), 3'b000};
				q_data.nbody   = nb;
			end
			REQ_SIZED: begin
				q_data.body_al = marked << {(4'd8 - sz), 3'b000};
				q_data.nbody   = sz;
			end
			REQ_MASTER: begin
				q_data.body_al = '0;
				q_data.nbody   = 4'd8;
			end
			REQ_MSIZE: begin
				q_data.nid     = 3'd0;
				q_data.body_al = {VINT_LEN8_MARK, val_s1[55:0]};
				q_data.nbody   = 4'd8;
			end
			default: begin
				q_data.nbody = 4'd8;
			end
		endcase
		// unencodable length: one zero byte flagged as error
		if ((type_s1 == REQ_SIZED && err1) || (type_s1 == REQ_MSIZE && err3)) begin
			q_data.nid    = 3'd0;
			q_data.hdr_en = 1'b1;
			q_data.hdr    = '0;
			q_data.nbody  = 4'd0;
			q_data.err    = 1'b1;
		end
	end

endmodule

>>> src/ehe_back.sv
// Back end: serializes one descriptor into bytes, one per transfer.
// Depends on ehe_pkg.
module ehe_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_nempty,
	input  ehe_pkg::desc_t q_data,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic           last,
	output logic           error
);
	import ehe_pkg::*;

	desc_t      cur_q;
	logic       busy_q;
	logic [3:0] remain;
	logic       out_fire;

	assign remain    = 4'(cur_q.nid) + 4'(cur_q.hdr_en) + cur_q.nbody;
	assign last      = (remain == 4'd1);
	assign error     = cur_q.err;
	assign out_valid = busy_q;
	assign out_fire  = out_valid && out_ready;
	assign q_pop     = q_nempty && (!busy_q || (out_fire && last));

	// pick the next byte: ID, then header byte, then body
	always_comb begin
		if (cur_q.nid != '0) begin
			out_byte = cur_q.id_al[31:24];
		end else if (cur_q.hdr_en) begin
			out_byte = cur_q.hdr;
		end else begin
			out_byte = cur_q.body_al[63:56];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
		end else if (out_fire && last) begin
			busy_q <= 1'b0;
		end
	end

	// load a new descriptor or drop the byte just sent
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end else if (out_fire) begin
			if (cur_q.nid != '0) begin
				cur_q.nid   <= cur_q.nid - 3'd1;
				cur_q.id_al <= {cur_q.id_al[23:0], 8'h00};
			end else if (cur_q.hdr_en) begin
				cur_q.hdr_en <= 1'b0;
			end else begin
				cur_q.nbody   <= cur_q.nbody - 4'd1;
				cur_q.body_al <= {cur_q.body_al[55:0], 8'h00};
			end
		end
	end

endmodule
